// ===== rtl/prx_pkg.sv =====
// shared constants and controller/datapath interface types for the printable run extractor
`default_nettype none
package prx_pkg;

	// default depth of the held-byte buffer
	localparam int MAX_MIN_LEN_DEF = 16;

	// field widths
	localparam int CFG_W  = 5;
	localparam int OFS_W  = 48;
	localparam int CHAR_W = 8;
	localparam int TDATA_W = 56;
	localparam int TUSER_W = 2;

	// minimum run length after reset
	localparam logic [CFG_W-1:0] MIN_LEN_RESET = 5'd4;

	// printable range, space to tilde
	localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7E;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// output byte source select
	localparam logic [1:0] SEL_IN   = 2'd0;
	localparam logic [1:0] SEL_HELD = 2'd1;
	localparam logic [1:0] SEL_CUR  = 2'd2;
	localparam logic [1:0] SEL_END  = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic       accept;     // capture input byte, advance position
		logic       set_start;  // run begins at the current position
		logic       hold_wr;    // append input byte to held buffer
		logic       rl_clr;     // clear held count and flush index
		logic       idx_inc;    // step flush index
		logic       out_load;   // load output register
		logic [1:0] out_sel;    // output byte source
		logic       out_first;  // first character of a string
		logic       out_last;   // final result of this request
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic printable;  // input byte is printable
		logic reach;      // held count plus one meets minimum
		logic rl_zero;    // nothing held
		logic rl_one;     // exactly one byte held
		logic idx_last;   // flush index at last held byte
		logic out_free;   // output register can take a result
		logic eod_q;      // captured byte was end of data
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/prx_datapath.sv =====
// datapath: position and run counters, held-byte buffer, config register, output register
`default_nettype none
module prx_datapath #(
	parameter int MAX_MIN_LEN = prx_pkg::MAX_MIN_LEN_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [prx_pkg::CHAR_W-1:0]    s_tdata,   // data_byte
	input  wire                           s_tlast,   // end_of_data
	input  wire                           cfg_valid,
	input  wire  [prx_pkg::CFG_W-1:0]     cfg_data,  // min_length
	input  wire                           m_tready,
	input  prx_pkg::cmd_t                 cmd,
	output prx_pkg::sts_t                 sts,
	output logic                          m_tvalid,
	output logic [prx_pkg::TDATA_W-1:0]   m_tdata,   // start_offset, char_code
	output logic [prx_pkg::TUSER_W-1:0]   m_tuser,   // kind, first_char
	output logic                          m_tlast    // last
);
	import prx_pkg::*;

	localparam int IW  = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
	localparam int RLW = $clog2(MAX_MIN_LEN + 1);
	localparam int CW  = ((RLW > CFG_W) ? RLW : CFG_W) + 1;

	logic [OFS_W-1:0]  pos_q;
	logic [OFS_W-1:0]  run_start_q;
	logic [RLW-1:0]    rl_q;
	logic [IW-1:0]     idx_q;
	logic [CFG_W-1:0]  min_len_q;
	logic [CHAR_W-1:0] cur_q;
	logic              eod_q;
	logic              m_tvalid_q;
	logic [CHAR_W-1:0] held_q [MAX_MIN_LEN];

	logic              out_free;
	logic [CW-1:0]     min_ext;
	logic [CW-1:0]     max_ext;
	logic [CW-1:0]     m_eff;
	logic [CHAR_W-1:0] out_byte;
	logic [OFS_W-1:0]  out_start;

	// effective minimum, clamped to 1..MAX_MIN_LEN
	always_comb begin
		min_ext = CW'(min_len_q);
		max_ext = CW'(MAX_MIN_LEN);
		if (min_len_q == '0) begin
			m_eff = CW'(1);
		end else if (min_ext > max_ext) begin
			m_eff = max_ext;
		end else begin
			m_eff = min_ext;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	// status to the controller
	always_comb begin
		sts.printable = (s_tdata >= PRINT_LO) && (s_tdata <= PRINT_HI);
		sts.reach     = (CW'(rl_q) + CW'(1)) >= m_eff;
		sts.rl_zero   = (rl_q == '0);
		sts.rl_one    = (rl_q == RLW'(1));
		sts.idx_last  = (RLW'(idx_q) == (rl_q - RLW'(1)));
		sts.out_free  = out_free;
		sts.eod_q     = eod_q;
	end

	// output byte and offset selection
	always_comb begin
		unique case (cmd.out_sel)
			SEL_IN:   out_byte = s_tdata;
			SEL_HELD: out_byte = held_q[idx_q];
			SEL_CUR:  out_byte = cur_q;
			SEL_END:  out_byte = '0;
		endcase
		out_start = cmd.set_start ? pos_q : run_start_q;
	end

	// control counters and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			run_start_q <= '0;
			rl_q        <= '0;
			idx_q       <= '0;
			min_len_q   <= MIN_LEN_RESET;
			eod_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				min_len_q <= cfg_data;
			end
			if (cmd.accept) begin
				eod_q <= s_tlast;
				pos_q <= s_tlast ? '0 : pos_q + OFS_W'(1);
			end
			if (cmd.set_start) begin
				run_start_q <= pos_q;
			end
			if (cmd.rl_clr) begin
				rl_q  <= '0;
				idx_q <= '0;
			end else begin
				if (cmd.hold_wr) begin
					rl_q <= rl_q + RLW'(1);
				end
				if (cmd.idx_inc) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload: held buffer, captured byte, output fields
	always_ff @(posedge clk) begin
		if (cmd.hold_wr) begin
			held_q[rl_q[IW-1:0]] <= s_tdata;
		end
		if (cmd.accept) begin
			cur_q <= s_tdata;
		end
		if (cmd.out_load) begin
			m_tdata <= {out_byte, out_start};
			m_tuser <= {cmd.out_first, (cmd.out_sel == SEL_END) ? KIND_END : KIND_CHAR};
			m_tlast <= cmd.out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

// ===== rtl/prx_ctrl.sv =====
// controller: sequences held-byte flush, current character and end marker per request
`default_nettype none
module prx_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            s_tvalid,
	input  wire            s_tlast,
	input  prx_pkg::sts_t  sts,
	output prx_pkg::cmd_t  cmd,
	output logic           s_tready
);
	import prx_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FLUSH = 2'd1;
	localparam logic [1:0] S_CUR   = 2'd2;
	localparam logic [1:0] S_END   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rep_q;
	logic       rep_d;

	assign s_tready = (state_q == S_IDLE) && sts.out_free;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		rep_d   = rep_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					cmd.accept = 1'b1;
					if (sts.printable) begin
						if (rep_q) begin
							// run already reported: stream this byte
							cmd.out_load = 1'b1;
							cmd.out_sel  = SEL_IN;
							cmd.out_last = !s_tlast;
							if (s_tlast) begin
								rep_d   = 1'b0;
								state_d = S_END;
							end
						end else if (sts.reach) begin
							// run reaches minimum: report it
							cmd.set_start = sts.rl_zero;
							rep_d         = !s_tlast;
							cmd.out_load  = 1'b1;
							cmd.out_first = 1'b1;
							if (sts.rl_zero) begin
								cmd.out_sel  = SEL_IN;
								cmd.out_last = !s_tlast;
								if (s_tlast) begin
									state_d = S_END;
								end
							end else begin
								cmd.out_sel = SEL_HELD;
								cmd.idx_inc = 1'b1;
								state_d     = sts.rl_one ? S_CUR : S_FLUSH;
							end
						end else begin
							// short run: hold the byte, or clear the held bytes at end of data
							cmd.set_start = sts.rl_zero;
							cmd.hold_wr   = !s_tlast;
							cmd.rl_clr    = s_tlast;
						end
					end else begin
						// non-printable closes the run
						cmd.rl_clr = 1'b1;
						rep_d      = 1'b0;
						if (rep_q) begin
							cmd.out_load = 1'b1;
							cmd.out_sel  = SEL_END;
							cmd.out_last = 1'b1;
						end
					end
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_HELD;
					cmd.idx_inc  = 1'b1;
					if (sts.idx_last) begin
						state_d = S_CUR;
					end
				end
			end
			S_CUR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_CUR;
					cmd.out_last = !sts.eod_q;
					cmd.rl_clr   = 1'b1;
					state_d      = sts.eod_q ? S_END : S_IDLE;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_END;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rep_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rep_q   <= rep_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/printable_run_extractor_top.sv =====
// top level of the printable run extractor
`default_nettype none
// Scans a byte stream (one byte per s_ request, s_tlast marks the final byte)
// and reports runs of printable ASCII (0x20..0x7E) at least min_length long.
// Each reported character leaves as one m_ result tagged with the zero-based
// offset where its run began; a closing byte or end of data adds an end
// marker (tuser kind = 1). min_length is written through cfg_valid/cfg_data,
// 0 acts as 1, values above MAX_MIN_LEN act as MAX_MIN_LEN. A single output
// register carries one result per cycle unless m_tready stalls it. A byte that
// causes at most one result leaves the controller idle for the next byte; a byte
// that completes a run of n held bytes yields n + 1 results, one more when end
// of data follows a character, and no new byte is taken until all are loaded.
module printable_run_extractor_top #(
	parameter int MAX_MIN_LEN = prx_pkg::MAX_MIN_LEN_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [prx_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] data_byte
	input  wire                           s_tlast,   // end_of_data
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [prx_pkg::TDATA_W-1:0]   m_tdata,   // [47:0] start_offset, [55:48] char_code
	output logic [prx_pkg::TUSER_W-1:0]   m_tuser,   // [0] kind, [1] first_char
	output logic                          m_tlast,   // last
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [prx_pkg::CFG_W-1:0]     cfg_data   // min_length
);
	import prx_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// sequencing
	prx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	// counters, buffer and output register
	prx_datapath #(
		.MAX_MIN_LEN (MAX_MIN_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/prx_checker.sv =====
// port-level checker for the printable run extractor and its bind
`default_nettype none
module prx_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_tready,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire [prx_pkg::TDATA_W-1:0]  m_tdata,
	input wire [prx_pkg::TUSER_W-1:0]  m_tuser,
	input wire                         m_tlast
);
	import prx_pkg::*;

	// stalled result stays valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// stalled result holds its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result payload changed while stalled");

	// end marker has zero code, no first flag, and closes the request
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == KIND_END) |->
			(m_tdata[55:48] == 8'h00) && !m_tuser[1] && m_tlast)
		else $error("malformed end marker");

	// reported characters are printable
	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == KIND_CHAR) |->
			(m_tdata[55:48] >= PRINT_LO) && (m_tdata[55:48] <= PRINT_HI))
		else $error("non-printable character reported");

	// a request is only taken when the output register can move
	a_in_gated: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("request taken while output register blocked");

endmodule

bind printable_run_extractor_top prx_checker u_prx_checker (.*);
`default_nettype wire

// ===== tb/sv/printable_run_extractor_top_tb.sv =====
// self-checking testbench for the printable run extractor top level
`timescale 1ns / 100ps

module printable_run_extractor_top_tb;

	localparam int HELD_DEPTH  = prx_pkg::MAX_MIN_LEN_DEF;
	localparam int PHASE_ITEMS = 36;
	localparam int SETTLE_CYC  = 20;
	localparam int MAX_WAIT    = 17;
	localparam int N_DIR       = 21;
	localparam int N_PHASE     = 8;

	// one reported string result
	typedef struct packed {
		logic                      kind;
		logic [prx_pkg::OFS_W-1:0] ofs;
		logic [prx_pkg::CHAR_W-1:0] ch;
		logic                      first;
		logic                      last;
	} str_res_t;

	// directed request, with a hand-written result where it is obvious
	typedef struct packed {
		logic [7:0] d;
		logic       eod;
		logic       typed;
		str_res_t   res;
	} dir_row_t;

	localparam str_res_t NO_RES = '{1'b0, 48'd0, 8'd0, 1'b0, 1'b0};

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [prx_pkg::CHAR_W-1:0]    s_tdata;
	logic                          s_tlast;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [prx_pkg::TDATA_W-1:0]   m_tdata;
	logic [prx_pkg::TUSER_W-1:0]   m_tuser;
	logic                          m_tlast;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [prx_pkg::CFG_W-1:0]     cfg_data;

	// scanner model state
	logic [prx_pkg::CFG_W-1:0]  min_len = prx_pkg::MIN_LEN_RESET;
	logic [prx_pkg::OFS_W-1:0]  next_ofs = '0;
	logic [prx_pkg::OFS_W-1:0]  run_ofs = '0;
	int unsigned                held_cnt = 0;
	logic [7:0]                 held [HELD_DEPTH];
	bit                         in_report = 1'b0;

	str_res_t step_res [$];
	str_res_t pending_res [$];
	int       err_cnt = 0;
	bit       tx_busy = 1'b1;
	bit       rx_busy = 1'b1;

	// directed stream, reset minimum of four
	dir_row_t dir_tab [N_DIR] = '{
		'{8'h57, 1'b0, 1'b0, NO_RES},   // run starts at offset zero
		'{8'h58, 1'b0, 1'b0, NO_RES},
		'{8'h59, 1'b0, 1'b0, NO_RES},
		'{8'h5A, 1'b0, 1'b0, NO_RES},   // reaches minimum, flush held bytes
		'{8'h7E, 1'b0, 1'b1, '{prx_pkg::KIND_CHAR, 48'd0, 8'h7E, 1'b0, 1'b1}},
		'{8'h00, 1'b0, 1'b1, '{prx_pkg::KIND_END, 48'd0, 8'h00, 1'b0, 1'b1}},
		'{8'h20, 1'b0, 1'b0, NO_RES},   // space opens a short run
		'{8'h7F, 1'b0, 1'b0, NO_RES},   // just above printable range
		'{8'h1F, 1'b0, 1'b0, NO_RES},   // just below printable range
		'{8'hFF, 1'b0, 1'b0, NO_RES},
		'{8'h80, 1'b0, 1'b0, NO_RES},
		'{8'h61, 1'b0, 1'b0, NO_RES},
		'{8'h62, 1'b0, 1'b0, NO_RES},
		'{8'h63, 1'b0, 1'b0, NO_RES},
		'{8'h64, 1'b1, 1'b0, NO_RES},   // minimum reached on the final byte
		'{8'h65, 1'b0, 1'b0, NO_RES},   // offset restarts at zero
		'{8'h66, 1'b0, 1'b0, NO_RES},
		'{8'h67, 1'b0, 1'b0, NO_RES},
		'{8'h68, 1'b0, 1'b0, NO_RES},
		'{8'h0A, 1'b1, 1'b1, '{prx_pkg::KIND_END, 48'd0, 8'h00, 1'b0, 1'b1}},
		'{8'h51, 1'b1, 1'b0, NO_RES}    // short run at end of data stays silent
	};

	logic [prx_pkg::CFG_W-1:0] phase_min [N_PHASE] =
		'{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd9, 5'd4};

	printable_run_extractor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// effective minimum after clamping
	function automatic int unsigned eff_min(input logic [prx_pkg::CFG_W-1:0] v);
		int unsigned m;
		m = 32'(v);
		if (m < 1)
			m = 1;
		if (m > HELD_DEPTH)
			m = HELD_DEPTH;
		return m;
	endfunction

	function automatic void note_result(input logic k, input logic [7:0] c, input logic f);
		str_res_t r;
		r.kind  = k;
		r.ofs   = run_ofs;
		r.ch    = c;
		r.first = f;
		r.last  = 1'b0;
		step_res.push_back(r);
	endfunction

	// advance the scanner by one byte, leaving its results in step_res
	function automatic void scan_byte(input logic [7:0] d, input logic eod);
		int unsigned m;
		int unsigned i;
		m = eff_min(min_len);
		step_res.delete();
		if (d >= prx_pkg::PRINT_LO && d <= prx_pkg::PRINT_HI) begin
			if (!in_report && held_cnt == 0)
				run_ofs = next_ofs;
			if (in_report) begin
				note_result(prx_pkg::KIND_CHAR, d, 1'b0);
			end else if (held_cnt + 1 >= m) begin
				for (i = 0; i < held_cnt; i++)
					note_result(prx_pkg::KIND_CHAR, held[i], i == 0);
				note_result(prx_pkg::KIND_CHAR, d, held_cnt == 0);
				held_cnt  = 0;
				in_report = 1'b1;
			end else if (held_cnt < HELD_DEPTH) begin
				held[held_cnt] = d;
				held_cnt++;
			end
		end else begin
			if (in_report)
				note_result(prx_pkg::KIND_END, 8'h00, 1'b0);
			in_report = 1'b0;
			held_cnt  = 0;
		end
		// end of data closes the stream
		if (eod) begin
			if (in_report)
				note_result(prx_pkg::KIND_END, 8'h00, 1'b0);
			in_report = 1'b0;
			held_cnt  = 0;
			next_ofs  = '0;
		end else begin
			next_ofs = next_ofs + 1'b1;
		end
		if (step_res.size() > 0)
			step_res[step_res.size()-1].last = 1'b1;
	endfunction

	// send one request; called and returns at a falling edge
	task automatic send_byte(input logic [7:0] d, input logic eod, input logic typed = 1'b0,
			input str_res_t typed_res = NO_RES);
		int gap;
		if ($urandom_range(0, 29) == 0)
			tx_busy = !tx_busy;
		gap = tx_busy ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = d;
		s_tlast  = eod;
		do @(posedge clk); while (!s_tready);
		scan_byte(d, eod);
		if (typed)
			pending_res.push_back(typed_res);
		else
			foreach (step_res[i]) pending_res.push_back(step_res[i]);
		@(negedge clk);
	endtask

	// hold the sender until every expected result has come out
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_res.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_min_len(input logic [prx_pkg::CFG_W-1:0] v);
		drain_results();
		repeat (SETTLE_CYC) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		min_len = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] rand_printable();
		return 8'($urandom_range(prx_pkg::PRINT_LO, prx_pkg::PRINT_HI));
	endfunction

	function automatic logic [7:0] rand_control();
		int unsigned v;
		v = $urandom_range(0, 160);
		return 8'((v < 32) ? v : v + 95);
	endfunction

	// stimulus
	initial begin
		int unsigned p;
		int unsigned sent;
		int unsigned len;
		int unsigned i;
		int unsigned m;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset minimum
		for (i = 0; i < N_DIR; i++)
			send_byte(dir_tab[i].d, dir_tab[i].eod, dir_tab[i].typed, dir_tab[i].res);

		// random part, one minimum setting per phase
		phase_min[6] = 5'($urandom_range(0, 31));
		for (p = 0; p < N_PHASE; p++) begin
			write_min_len(phase_min[p]);
			m = eff_min(phase_min[p]);
			// a run that reaches the minimum on the final byte
			for (i = 0; i < m; i++)
				send_byte(rand_printable(), i == m - 1);
			sent = m;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
					sent++;
				end else begin
					len = $urandom_range(0, 20);
					for (i = 0; i < len; i++)
						send_byte(rand_printable(), (i == len - 1) && ($urandom_range(0, 7) == 0));
					send_byte(rand_control(), $urandom_range(0, 5) == 0);
					sent += len + 1;
				end
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
		end

		// wind down
		drain_results();
		repeat (SETTLE_CYC) @(negedge clk);
		if (err_cnt == 0 && pending_res.size() == 0) begin
			$display("printable_run_extractor_top_tb: PASS");
		end else begin
			if (pending_res.size() > 0)
				$display("%0t: %0d expected results never arrived", $time, pending_res.size());
			$display("printable_run_extractor_top_tb: FAIL");
		end
		$finish;
	end

	// result sink with random stalls
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 29) == 0)
				rx_busy = !rx_busy;
			stall = rx_busy ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each accepted result against the oldest expectation
	always @(posedge clk) begin
		str_res_t got;
		str_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind  = m_tuser[0];
			got.first = m_tuser[1];
			got.ofs   = m_tdata[prx_pkg::OFS_W-1:0];
			got.ch    = m_tdata[prx_pkg::OFS_W +: prx_pkg::CHAR_W];
			got.last  = m_tlast;
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result kind=%0b ofs=%0d ch=%02h first=%0b last=%0b",
					$time, got.kind, got.ofs, got.ch, got.first, got.last);
				err_cnt++;
			end else begin
				want = pending_res.pop_front();
				if (got.kind !== want.kind || got.ofs !== want.ofs || got.ch !== want.ch ||
						got.first !== want.first || got.last !== want.last) begin
					$display("%0t: mismatch expected kind=%0b ofs=%0d ch=%02h first=%0b last=%0b",
						$time, want.kind, want.ofs, want.ch, want.first, want.last);
					$display("%0t:          actual   kind=%0b ofs=%0d ch=%02h first=%0b last=%0b",
						$time, got.kind, got.ofs, got.ch, got.first, got.last);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("%0t: timeout", $time);
		$display("printable_run_extractor_top_tb: FAIL");
		$finish;
	end

endmodule
